// File: sv/vtg_pkg.sv
// Package for the text grid terminal: grid geometry, character codes,
// cell layout and the item and port structs that the modules share.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vtg_pkg;

    localparam int GRID_COLS  = 80;
    localparam int GRID_ROWS  = 24;
    localparam int MAX_PARAMS = 8;
    localparam int NCELLS     = GRID_COLS * GRID_ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam int PCNT_W = $clog2(MAX_PARAMS + 1);
    localparam int PIDX_W = $clog2(MAX_PARAMS);
    localparam int K_W    = $clog2(MAX_PARAMS + 6);

    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [3:0]  FG_DEFAULT = 4'd7;
    localparam logic [3:0]  BG_DEFAULT = 4'd0;

    // Host byte codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_QUEST = 8'd63;
    localparam logic [7:0] CH_FIN_LO = 8'd64;
    localparam logic [7:0] CH_FIN_HI = 8'd126;
    localparam logic [7:0] CH_LBRK  = 8'd91;
    localparam logic [7:0] FIN_A    = 8'd65;
    localparam logic [7:0] FIN_B    = 8'd66;
    localparam logic [7:0] FIN_C    = 8'd67;
    localparam logic [7:0] FIN_D    = 8'd68;
    localparam logic [7:0] FIN_G    = 8'd71;
    localparam logic [7:0] FIN_H    = 8'd72;
    localparam logic [7:0] FIN_J    = 8'd74;
    localparam logic [7:0] FIN_K    = 8'd75;
    localparam logic [7:0] FIN_LD   = 8'd100;
    localparam logic [7:0] FIN_LF   = 8'd102;
    localparam logic [7:0] FIN_LH   = 8'd104;
    localparam logic [7:0] FIN_LL   = 8'd108;
    localparam logic [7:0] FIN_LM   = 8'd109;

    // Item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [7:0]       byte_value;
        logic [IDX_W-1:0] cell_index;
    } vtg_req_t;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [3:0]       cell_fg;
        logic [3:0]       cell_bg;
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic             cursor_shown;
    } vtg_resp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } vtg_mem_t;

    typedef struct packed {
        logic             take;
        logic             outside;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             shown;
    } vtg_rdstat_t;

endpackage

`default_nettype wire

// File: sv/vtg_grid_ram.sv
// Character grid storage: one write port, one read port, registered read.
// Depends on vtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtg_grid_ram (
    input  wire logic             clk,
    input  wire vtg_pkg::vtg_mem_t mem,
    output logic [15:0]           rdata
);
    import vtg_pkg::*;

    logic [15:0] grid_reg [NCELLS];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem.we)
        begin
            grid_reg[mem.waddr] <= mem.wdata;
        end
        if (mem.re)
        begin
            rdata_reg <= grid_reg[mem.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/vtg_engine.sv
// Byte parser, cursor and attribute state, and the grid sequencer that
// drives the cell memory (print, scroll copy, blank sweeps, cell reads).
// Depends on vtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vtg_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire vtg_pkg::vtg_req_t  request,
    input  wire logic [15:0]        rdata,
    output logic                    busy,
    output vtg_pkg::vtg_mem_t       mem,
    output vtg_pkg::vtg_rdstat_t    rdstat
);
    import vtg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_BLANK  = 6'b010000,
        ST_SGR    = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_ESC    = 3'b010,
        PH_CSI    = 3'b100
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              wrap_reg, wrap_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic              bold_reg, bold_next;
    logic              rev_reg, rev_next;
    logic              vis_reg, vis_next;
    logic              priv_reg, priv_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [15:0]       pval_reg [MAX_PARAMS];
    logic [15:0]       pval_next [MAX_PARAMS];
    logic [K_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [CNT_W-1:0]  scr_rd_reg, scr_rd_next;
    logic              vld_reg, vld_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic [7:0]        char_reg, char_next;
    logic              oob_reg, oob_next;

    logic [7:0]        c;
    logic [CNT_W-1:0]  here, row0;
    logic [15:0]       p0, p1, n;
    logic [PIDX_W-1:0] didx;
    logic [19:0]       acc;
    logic [PCNT_W-1:0] pe;
    logic [COL_W:0]    tab;
    logic [K_W-1:0]    k1, k2, kcnt;
    logic [15:0]       sp, sv1, sv2;
    logic [3:0]        af, ab, fsel;

    function automatic logic [ROW_W-1:0] sat_row(input logic [16:0] v);
        if (v > 17'(GRID_ROWS - 1))
        begin
            return ROW_W'(GRID_ROWS - 1);
        end
        return v[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] sat_col(input logic [16:0] v);
        if (v > 17'(GRID_COLS - 1))
        begin
            return COL_W'(GRID_COLS - 1);
        end
        return v[COL_W-1:0];
    endfunction

    assign c    = request.byte_value;
    assign here = CNT_W'(32'(row_reg) * GRID_COLS + 32'(col_reg));
    assign row0 = CNT_W'(32'(row_reg) * GRID_COLS);
    assign p0   = (pcnt_reg != '0) ? pval_reg[0] : 16'd0;
    assign p1   = (pcnt_reg > PCNT_W'(1)) ? pval_reg[1] : 16'd0;
    assign n    = (p0 == 16'd0) ? 16'd1 : p0;
    assign didx = (pcnt_reg == '0) ? '0 : PIDX_W'(pcnt_reg - PCNT_W'(1));
    assign acc  = 20'(pval_reg[didx]) * 20'd10 + 20'(c - CH_0);
    assign pe   = (pcnt_reg == '0) ? PCNT_W'(1) : pcnt_reg;
    assign tab  = ({1'b0, col_reg} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
    assign k1   = k_reg + K_W'(1);
    assign k2   = k_reg + K_W'(2);
    assign kcnt = K_W'(pcnt_reg);
    assign sp   = pval_reg[k_reg[PIDX_W-1:0]];
    assign sv1  = pval_reg[k1[PIDX_W-1:0]];
    assign sv2  = pval_reg[k2[PIDX_W-1:0]];
    assign fsel = (bold_reg && !fg_reg[3]) ? (fg_reg | 4'd8) : fg_reg;
    assign af   = rev_reg ? bg_reg : fsel;
    assign ab   = rev_reg ? fsel : bg_reg;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        wrap_next   = wrap_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        bold_next   = bold_reg;
        rev_next    = rev_reg;
        vis_next    = vis_reg;
        priv_next   = priv_reg;
        pcnt_next   = pcnt_reg;
        pval_next   = pval_reg;
        k_next      = k_reg;
        addr_next   = addr_reg;
        end_next    = end_reg;
        scr_rd_next = scr_rd_reg;
        vld_next    = 1'b0;
        wa_next     = wa_reg;
        pend_next   = pend_reg;
        char_next   = char_reg;
        oob_next    = oob_reg;
        mem         = '0;
        rdstat      = '0;
        rdstat.col   = col_reg;
        rdstat.row   = row_reg;
        rdstat.shown = vis_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (request.kind == KIND_READ)
                    begin
                        oob_next   = (32'(request.cell_index) >= NCELLS);
                        mem.re     = 1'b1;
                        mem.raddr  = ADDR_W'(request.cell_index);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_ESC:
                            begin
                                if (c == CH_LBRK)
                                begin
                                    phase_next   = PH_CSI;
                                    pcnt_next    = '0;
                                    priv_next    = 1'b0;
                                    pval_next[0] = 16'd0;
                                end
                                else
                                begin
                                    phase_next = PH_NORMAL;
                                end
                            end
                            PH_CSI:
                            begin
                                if (c == CH_QUEST)
                                begin
                                    priv_next = 1'b1;
                                end
                                else if (c >= CH_0 && c <= CH_9)
                                begin
                                    pcnt_next = pe;
                                    pval_next[didx] = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                                end
                                else if (c == CH_SEMI)
                                begin
                                    if (32'(pe) < MAX_PARAMS)
                                    begin
                                        pval_next[pe[PIDX_W-1:0]] = 16'd0;
                                        pcnt_next = pe + PCNT_W'(1);
                                    end
                                    else
                                    begin
                                        pcnt_next = pe;
                                    end
                                end
                                else
                                begin
                                    phase_next = PH_NORMAL;
                                    if (c >= CH_FIN_LO && c <= CH_FIN_HI)
                                    begin
                                        wrap_next = 1'b0;
                                        unique case (c) inside
                                            FIN_LM:
                                            begin
                                                state_next = ST_SGR;
                                                k_next     = '0;
                                                if (pcnt_reg == '0)
                                                begin
                                                    pcnt_next    = PCNT_W'(1);
                                                    pval_next[0] = 16'd0;
                                                end
                                            end
                                            FIN_H, FIN_LF:
                                            begin
                                                row_next = sat_row((p0 == 16'd0) ? 17'd0
                                                                   : {1'b0, p0} - 17'd1);
                                                col_next = sat_col((p1 == 16'd0) ? 17'd0
                                                                   : {1'b0, p1} - 17'd1);
                                            end
                                            FIN_A:
                                            begin
                                                row_next = ({1'b0, n} > 17'(row_reg)) ? '0
                                                           : row_reg - n[ROW_W-1:0];
                                            end
                                            FIN_B:
                                            begin
                                                row_next = sat_row(17'(row_reg) + {1'b0, n});
                                            end
                                            FIN_C:
                                            begin
                                                col_next = sat_col(17'(col_reg) + {1'b0, n});
                                            end
                                            FIN_D:
                                            begin
                                                col_next = ({1'b0, n} > 17'(col_reg)) ? '0
                                                           : col_reg - n[COL_W-1:0];
                                            end
                                            FIN_G:
                                            begin
                                                col_next = sat_col({1'b0, n} - 17'd1);
                                            end
                                            FIN_LD:
                                            begin
                                                row_next = sat_row({1'b0, n} - 17'd1);
                                            end
                                            FIN_J:
                                            begin
                                                state_next = ST_BLANK;
                                                if (p0 == 16'd2 || p0 == 16'd3)
                                                begin
                                                    addr_next = '0;
                                                    end_next  = CNT_W'(NCELLS);
                                                end
                                                else if (p0 == 16'd1)
                                                begin
                                                    addr_next = '0;
                                                    end_next  = here + CNT_W'(1);
                                                end
                                                else
                                                begin
                                                    addr_next = here;
                                                    end_next  = CNT_W'(NCELLS);
                                                end
                                            end
                                            FIN_K:
                                            begin
                                                state_next = ST_BLANK;
                                                if (p0 == 16'd2)
                                                begin
                                                    addr_next = row0;
                                                    end_next  = row0 + CNT_W'(GRID_COLS);
                                                end
                                                else if (p0 == 16'd1)
                                                begin
                                                    addr_next = row0;
                                                    end_next  = here + CNT_W'(1);
                                                end
                                                else
                                                begin
                                                    addr_next = here;
                                                    end_next  = row0 + CNT_W'(GRID_COLS);
                                                end
                                            end
                                            FIN_LH, FIN_LL:
                                            begin
                                                if (priv_reg && p0 == 16'd25)
                                                begin
                                                    vis_next = (c == FIN_LH);
                                                end
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = PH_NORMAL;
                                if (c == CH_ESC)
                                begin
                                    phase_next = PH_ESC;
                                end
                                else if (c == CH_LF)
                                begin
                                    col_next  = '0;
                                    wrap_next = 1'b0;
                                    if (32'(row_reg) == GRID_ROWS - 1)
                                    begin
                                        scr_rd_next = CNT_W'(GRID_COLS);
                                        pend_next   = 1'b0;
                                        state_next  = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        row_next = row_reg + ROW_W'(1);
                                    end
                                end
                                else if (c == CH_CR)
                                begin
                                    col_next  = '0;
                                    wrap_next = 1'b0;
                                end
                                else if (c == CH_BS)
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - COL_W'(1);
                                    end
                                    wrap_next = 1'b0;
                                end
                                else if (c == CH_TAB)
                                begin
                                    col_next = (32'(tab) >= GRID_COLS) ? COL_W'(GRID_COLS - 1)
                                               : tab[COL_W-1:0];
                                end
                                else if (c >= CH_SPACE)
                                begin
                                    char_next  = c;
                                    state_next = ST_WRITE;
                                    if (wrap_reg)
                                    begin
                                        col_next  = '0;
                                        wrap_next = 1'b0;
                                        if (32'(row_reg) == GRID_ROWS - 1)
                                        begin
                                            scr_rd_next = CNT_W'(GRID_COLS);
                                            pend_next   = 1'b1;
                                            state_next  = ST_SCROLL;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + ROW_W'(1);
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            ST_READ:
            begin
                rdstat.take    = 1'b1;
                rdstat.outside = oob_reg;
                state_next     = ST_IDLE;
            end

            ST_WRITE:
            begin
                mem.we    = 1'b1;
                mem.waddr = ADDR_W'(here);
                mem.wdata = {ab, af, char_reg};
                if (32'(col_reg) == GRID_COLS - 1)
                begin
                    wrap_next = 1'b1;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                state_next = ST_IDLE;
            end

            ST_SCROLL:
            begin
                // copy row r+1 onto row r, writing each cell in the cycle after its read
                if (vld_reg)
                begin
                    mem.we    = 1'b1;
                    mem.waddr = wa_reg;
                    mem.wdata = rdata;
                end
                if (32'(scr_rd_reg) < NCELLS)
                begin
                    mem.re      = 1'b1;
                    mem.raddr   = ADDR_W'(scr_rd_reg);
                    scr_rd_next = scr_rd_reg + CNT_W'(1);
                    vld_next    = 1'b1;
                    wa_next     = ADDR_W'(scr_rd_reg - CNT_W'(GRID_COLS));
                end
                else
                begin
                    addr_next  = CNT_W'((GRID_ROWS - 1) * GRID_COLS);
                    end_next   = CNT_W'(NCELLS);
                    state_next = ST_BLANK;
                end
            end

            ST_BLANK:
            begin
                mem.we    = 1'b1;
                mem.waddr = ADDR_W'(addr_reg);
                mem.wdata = BLANK_CELL;
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg + CNT_W'(1) >= end_reg)
                begin
                    state_next = pend_reg ? ST_WRITE : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end

            ST_SGR:
            begin
                if (k_reg >= kcnt)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next = k1;
                    if (sp == 16'd0)
                    begin
                        fg_next   = FG_DEFAULT;
                        bg_next   = BG_DEFAULT;
                        bold_next = 1'b0;
                        rev_next  = 1'b0;
                    end
                    else if (sp == 16'd1)
                    begin
                        bold_next = 1'b1;
                    end
                    else if (sp == 16'd22)
                    begin
                        bold_next = 1'b0;
                    end
                    else if (sp == 16'd7)
                    begin
                        rev_next = 1'b1;
                    end
                    else if (sp == 16'd27)
                    begin
                        rev_next = 1'b0;
                    end
                    else if (sp >= 16'd30 && sp <= 16'd37)
                    begin
                        fg_next = 4'(sp - 16'd30);
                    end
                    else if (sp == 16'd39)
                    begin
                        fg_next = FG_DEFAULT;
                    end
                    else if (sp >= 16'd40 && sp <= 16'd47)
                    begin
                        bg_next = 4'(sp - 16'd40);
                    end
                    else if (sp == 16'd49)
                    begin
                        bg_next = BG_DEFAULT;
                    end
                    else if (sp >= 16'd90 && sp <= 16'd97)
                    begin
                        fg_next = 4'(sp - 16'd82);
                    end
                    else if (sp >= 16'd100 && sp <= 16'd107)
                    begin
                        bg_next = 4'(sp - 16'd92);
                    end
                    else if (sp == 16'd38 || sp == 16'd48)
                    begin
                        if (k2 < kcnt && sv1 == 16'd5)
                        begin
                            if (sv2 < 16'd16)
                            begin
                                if (sp == 16'd38)
                                begin
                                    fg_next = sv2[3:0];
                                end
                                else
                                begin
                                    bg_next = sv2[3:0];
                                end
                            end
                            k_next = k_reg + K_W'(3);
                        end
                        else if (k1 < kcnt && sv1 == 16'd2)
                        begin
                            k_next = k_reg + K_W'(5);
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_BLANK;
            phase_reg  <= PH_NORMAL;
            col_reg    <= '0;
            row_reg    <= '0;
            wrap_reg   <= 1'b0;
            fg_reg     <= FG_DEFAULT;
            bg_reg     <= BG_DEFAULT;
            bold_reg   <= 1'b0;
            rev_reg    <= 1'b0;
            vis_reg    <= 1'b1;
            priv_reg   <= 1'b0;
            pcnt_reg   <= '0;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                pval_reg[i] <= 16'd0;
            end
            k_reg      <= '0;
            addr_reg   <= '0;
            end_reg    <= CNT_W'(NCELLS);
            scr_rd_reg <= '0;
            vld_reg    <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            wrap_reg   <= wrap_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            bold_reg   <= bold_next;
            rev_reg    <= rev_next;
            vis_reg    <= vis_next;
            priv_reg   <= priv_next;
            pcnt_reg   <= pcnt_next;
            pval_reg   <= pval_next;
            k_reg      <= k_next;
            addr_reg   <= addr_next;
            end_reg    <= end_next;
            scr_rd_reg <= scr_rd_next;
            vld_reg    <= vld_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg   <= wa_next;
        char_reg <= char_next;
        oob_reg  <= oob_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// File: sv/vt100_text_grid_terminal.sv
// Top level of the text grid terminal: byte engine, grid memory, result register.
// Depends on vtg_pkg, vtg_engine and vtg_grid_ram.
// A read item passes the engine's read state, then the result register that raises the strobe.
// A printable byte also passes the cell write state; other plain bytes end in idle; SGR walks its params.
// Erase walks one cell a cycle (up to 1920); bottom-row scroll copies 1840 cells then blanks 80.
// Reset: busy for a clearing pass over all 1920 cells of the grid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module vt100_text_grid_terminal (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire vtg_pkg::vtg_req_t  request,
    output logic                    busy,
    output logic                    response_valid,
    output vtg_pkg::vtg_resp_t      response
);
    import vtg_pkg::*;

    vtg_mem_t    mem;
    vtg_rdstat_t rdstat;
    logic [15:0] rdata;
    vtg_resp_t   resp_reg, resp_next;
    logic        valid_reg;

    // Parser, cursor and grid sequencer; owns every write to the grid.
    vtg_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .rdata   (rdata),
        .busy    (busy),
        .mem     (mem),
        .rdstat  (rdstat)
    );

    // Cell storage with a registered read.
    vtg_grid_ram u_ram (
        .clk   (clk),
        .mem   (mem),
        .rdata (rdata)
    );

    // Build the result from the read cell; an index beyond the grid reads as zero.
    always_comb
    begin
        resp_next               = resp_reg;
        if (rdstat.take)
        begin
            resp_next.cell_char     = rdstat.outside ? 8'd0 : rdata[7:0];
            resp_next.cell_fg       = rdstat.outside ? 4'd0 : rdata[11:8];
            resp_next.cell_bg       = rdstat.outside ? 4'd0 : rdata[15:12];
            resp_next.cursor_column = rdstat.col;
            resp_next.cursor_row    = rdstat.row;
            resp_next.cursor_shown  = rdstat.shown;
        end
    end

    // Hold the result in its own register so the engine can take the next item.
    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    // Raise the strobe for exactly one cycle per read item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= rdstat.take;
        end
    end

    assign response_valid = valid_reg;
    assign response       = resp_reg;

endmodule

`default_nettype wire

// File: sv/vtg_checker.sv
// Port-level checks for the text grid terminal, bound to the top level.
// Depends on vtg_pkg and vt100_text_grid_terminal.
`timescale 1ns / 1ps
`default_nettype none

module vtg_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire vtg_pkg::vtg_req_t  request,
    input wire logic               busy,
    input wire logic               response_valid,
    input wire vtg_pkg::vtg_resp_t response
);
    import vtg_pkg::*;

    logic acc_read, acc_byte;

    assign acc_read = start && !busy && (request.kind == KIND_READ);
    assign acc_byte = start && !busy && (request.kind == KIND_BYTE);

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read |-> ##2 response_valid)
        else $error("read item gave no result two cycles later");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc_read |=> busy)
        else $error("block took a new item while a read was outstanding");

    a_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        acc_byte |=> !response_valid)
        else $error("byte item produced a result");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        response_valid |-> (32'(response.cursor_column) < GRID_COLS)
                           && (32'(response.cursor_row) < GRID_ROWS))
        else $error("cursor outside the grid");

endmodule

bind vt100_text_grid_terminal vtg_checker u_vtg_checker (.*);

`default_nettype wire

// File: dv/vt100_text_grid_terminal_tb.sv
// Testbench for the text grid terminal: drives host bytes and cell reads,
// predicts every read result with its own grid model and checks it.
// Depends on vtg_pkg and the vt100_text_grid_terminal RTL.
`timescale 1ns / 1ps

class grid_scoreboard;
    bit [15:0] cells [vtg_pkg::NCELLS];
    int col, row;
    bit wrap, bold, rev, shown;
    bit [3:0] fg, bg;
    bit [1:0] phase;
    int pcnt;
    int unsigned pv [vtg_pkg::MAX_PARAMS];
    bit priv;
    vtg_pkg::vtg_resp_t pending_reads [$];
    int mismatches;

    function new();
        for (int k = 0; k < vtg_pkg::NCELLS; k++) cells[k] = vtg_pkg::BLANK_CELL;
        col = 0; row = 0; wrap = 0; bold = 0; rev = 0; shown = 1;
        fg = vtg_pkg::FG_DEFAULT; bg = vtg_pkg::BG_DEFAULT;
        phase = 0; pcnt = 0; priv = 0; mismatches = 0;
        foreach (pv[i]) pv[i] = 0;
    endfunction

    function void blank(int lo, int hi);
        if (lo < 0) lo = 0;
        if (hi > vtg_pkg::NCELLS) hi = vtg_pkg::NCELLS;
        for (int k = lo; k < hi; k++) cells[k] = vtg_pkg::BLANK_CELL;
    endfunction

    function void line_feed();
        col = 0; wrap = 0; row++;
        if (row >= vtg_pkg::GRID_ROWS) begin
            for (int k = 0; k < vtg_pkg::NCELLS - vtg_pkg::GRID_COLS; k++)
                cells[k] = cells[k + vtg_pkg::GRID_COLS];
            blank(vtg_pkg::NCELLS - vtg_pkg::GRID_COLS, vtg_pkg::NCELLS);
            row = vtg_pkg::GRID_ROWS - 1;
        end
    endfunction

    function void put_char(bit [7:0] c);
        bit [3:0] f, b, x;
        if (wrap) line_feed();
        f = fg; b = bg;
        if (bold && f < 8) f += 8;
        if (rev) begin x = f; f = b; b = x; end
        cells[row * vtg_pkg::GRID_COLS + col] = {b, f, c};
        col++;
        if (col >= vtg_pkg::GRID_COLS) begin col = vtg_pkg::GRID_COLS - 1; wrap = 1; end
    endfunction

    function void set_graphics();
        int k, cnt;
        int unsigned p, v;
        k = 0; cnt = pcnt;
        if (cnt == 0) begin cnt = 1; pv[0] = 0; end
        while (k < cnt) begin
            p = pv[k];
            if (p == 0) begin
                fg = vtg_pkg::FG_DEFAULT; bg = vtg_pkg::BG_DEFAULT; bold = 0; rev = 0;
            end
            else if (p == 1) bold = 1;
            else if (p == 22) bold = 0;
            else if (p == 7) rev = 1;
            else if (p == 27) rev = 0;
            else if (p >= 30 && p <= 37) fg = 4'(p - 30);
            else if (p == 39) fg = vtg_pkg::FG_DEFAULT;
            else if (p >= 40 && p <= 47) bg = 4'(p - 40);
            else if (p == 49) bg = vtg_pkg::BG_DEFAULT;
            else if (p >= 90 && p <= 97) fg = 4'(p - 90 + 8);
            else if (p >= 100 && p <= 107) bg = 4'(p - 100 + 8);
            else if (p == 38 || p == 48) begin
                if (k + 2 < cnt && pv[k + 1] == 5) begin
                    v = pv[k + 2];
                    if (v < 16) begin if (p == 38) fg = 4'(v); else bg = 4'(v); end
                    k += 2;
                end else if (k + 1 < cnt && pv[k + 1] == 2) k += 4;
            end
            k++;
        end
        pcnt = cnt;
    endfunction

    function void do_final(bit [7:0] fin);
        int p0, p1, n, here, row0;
        p0 = pcnt > 0 ? int'(pv[0]) : 0;
        p1 = pcnt > 1 ? int'(pv[1]) : 0;
        n = p0 ? p0 : 1;
        here = row * vtg_pkg::GRID_COLS + col;
        row0 = row * vtg_pkg::GRID_COLS;
        wrap = 0;
        case (fin)
            vtg_pkg::FIN_LM: set_graphics();
            vtg_pkg::FIN_H, vtg_pkg::FIN_LF:
            begin
                row = (p0 ? p0 : 1) - 1; col = (p1 ? p1 : 1) - 1;
            end
            vtg_pkg::FIN_A: row -= n;
            vtg_pkg::FIN_B: row += n;
            vtg_pkg::FIN_C: col += n;
            vtg_pkg::FIN_D: col -= n;
            vtg_pkg::FIN_G: col = n - 1;
            vtg_pkg::FIN_LD: row = n - 1;
            vtg_pkg::FIN_J:
            begin
                if (p0 == 2 || p0 == 3) blank(0, vtg_pkg::NCELLS);
                else if (p0 == 1) blank(0, here + 1);
                else blank(here, vtg_pkg::NCELLS);
            end
            vtg_pkg::FIN_K:
            begin
                if (p0 == 2) blank(row0, row0 + vtg_pkg::GRID_COLS);
                else if (p0 == 1) blank(row0, here + 1);
                else blank(here, row0 + vtg_pkg::GRID_COLS);
            end
            vtg_pkg::FIN_LH, vtg_pkg::FIN_LL:
                if (priv && p0 == 25) shown = (fin == vtg_pkg::FIN_LH);
            default: ;
        endcase
        if (col < 0) col = 0;
        if (row < 0) row = 0;
        if (col >= vtg_pkg::GRID_COLS) col = vtg_pkg::GRID_COLS - 1;
        if (row >= vtg_pkg::GRID_ROWS) row = vtg_pkg::GRID_ROWS - 1;
    endfunction

    function void feed_byte(bit [7:0] c);
        int unsigned v;
        if (phase == 1) begin
            if (c == vtg_pkg::CH_LBRK) begin phase = 2; pcnt = 0; priv = 0; pv[0] = 0; end
            else phase = 0;
            return;
        end
        if (phase == 2) begin
            if (c == vtg_pkg::CH_QUEST) begin priv = 1; return; end
            if (c >= vtg_pkg::CH_0 && c <= vtg_pkg::CH_9) begin
                if (pcnt == 0) pcnt = 1;
                v = pv[pcnt - 1] * 10 + (c - vtg_pkg::CH_0);
                if (v > 65535) v = 65535;
                pv[pcnt - 1] = v;
                return;
            end
            if (c == vtg_pkg::CH_SEMI) begin
                if (pcnt == 0) pcnt = 1;
                if (pcnt < vtg_pkg::MAX_PARAMS) begin pv[pcnt] = 0; pcnt++; end
                return;
            end
            phase = 0;
            if (c >= vtg_pkg::CH_FIN_LO && c <= vtg_pkg::CH_FIN_HI) do_final(c);
            return;
        end
        phase = 0;
        if (c == vtg_pkg::CH_ESC) phase = 1;
        else if (c == vtg_pkg::CH_LF) line_feed();
        else if (c == vtg_pkg::CH_CR) begin col = 0; wrap = 0; end
        else if (c == vtg_pkg::CH_BS) begin if (col > 0) col--; wrap = 0; end
        else if (c == vtg_pkg::CH_TAB) begin
            col = (col + 8) & ~7;
            if (col >= vtg_pkg::GRID_COLS) col = vtg_pkg::GRID_COLS - 1;
        end else if (c >= vtg_pkg::CH_SPACE) put_char(c);
    endfunction

    // Note one accepted item: bytes update the model, reads queue a result.
    function void note_item(vtg_pkg::vtg_req_t it);
        vtg_pkg::vtg_resp_t r;
        bit [15:0] cell_word;
        if (it.kind == vtg_pkg::KIND_BYTE) begin
            feed_byte(it.byte_value);
            return;
        end
        cell_word = (it.cell_index < vtg_pkg::NCELLS) ? cells[it.cell_index] : 16'h0;
        r.cell_char = cell_word[7:0];
        r.cell_fg = cell_word[11:8];
        r.cell_bg = cell_word[15:12];
        r.cursor_column = vtg_pkg::COL_W'(col);
        r.cursor_row = vtg_pkg::ROW_W'(row);
        r.cursor_shown = shown;
        pending_reads.push_back(r);
    endfunction

    function void check_result(vtg_pkg::vtg_resp_t got);
        vtg_pkg::vtg_resp_t want;
        if (pending_reads.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_reads.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: want char %h fg %h bg %h col %0d row %0d shown %b,",
                          " got char %h fg %h bg %h col %0d row %0d shown %b"},
                         want.cell_char, want.cell_fg, want.cell_bg, want.cursor_column,
                         want.cursor_row, want.cursor_shown, got.cell_char, got.cell_fg,
                         got.cell_bg, got.cursor_column, got.cursor_row, got.cursor_shown);
        end
    endfunction
endclass

module vt100_text_grid_terminal_tb;
    import vtg_pkg::*;

    // Watchdog: a scroll or full erase holds busy while it walks the grid,
    // as does the reset clearing pass; the limit allows several times the longest.
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    vtg_req_t request = '0;
    logic busy;
    logic response_valid;
    vtg_resp_t response;

    grid_scoreboard grid_sb;
    int idle_cycles = 0;
    bit timed_out = 0;
    bit quiet_stretch = 0;

    vt100_text_grid_terminal uut (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .response_valid(response_valid), .response(response)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sample at the rising edge: note accepted items, check strobed results.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy) begin
                grid_sb.note_item(request);
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (response_valid) grid_sb.check_result(response);
            if (idle_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("vt100_text_grid_terminal_tb: FAIL");
                $finish;
            end
        end
    end

    // Present one item from the falling edge and hold it until accepted;
    // leave start high when the next item follows back to back.
    task automatic send_item(vtg_req_t it);
        while (!quiet_stretch && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(negedge clk);
        end
        request <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_byte(bit [7:0] b);
        vtg_req_t it;
        it.kind = KIND_BYTE;
        it.byte_value = b;
        it.cell_index = 11'($urandom_range(2047));
        send_item(it);
    endtask

    task automatic send_read(bit [10:0] idx);
        vtg_req_t it;
        it.kind = KIND_READ;
        it.byte_value = 8'($urandom_range(255));
        it.cell_index = idx;
        send_item(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Pick a read index: often in the cursor row, else anywhere in the grid, sometimes beyond it.
    function automatic bit [10:0] pick_index();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 11'($urandom_range(2047));
        if (r < 50) return 11'(grid_sb.row * GRID_COLS + $urandom_range(GRID_COLS - 1));
        return 11'($urandom_range(NCELLS - 1));
    endfunction

    // Build one well-formed control sequence with random content.
    task automatic send_sequence();
        int n, pick;
        string fins;
        fins = "mmmmHfABCDGdJKhlmz";
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        if ($urandom_range(9) == 0) send_byte(CH_QUEST);
        pick = $urandom_range(9);
        n = $urandom_range(pick == 0 ? 11 : 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0) send_byte(CH_SEMI);
            case ($urandom_range(5))
                0: send_text($sformatf("%0d", $urandom_range(9)));
                1: send_text($sformatf("%0d", $urandom_range(40)));
                2: send_text($sformatf("%0d", 30 + $urandom_range(17)));
                3: send_text($sformatf("%0d", 90 + $urandom_range(17)));
                4: send_text($sformatf("%0d", $urandom_range(99999)));
                default: ;
            endcase
        end
        send_byte(fins[$urandom_range(fins.len() - 1)]);
    endtask

    initial
    begin
        int sent;
        grid_sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, controls, wrap, tab, edges, sequence corners.
        quiet_stretch = 1;
        send_read(11'd0);
        send_read(11'(NCELLS - 1));
        send_read(11'(NCELLS));
        send_read(11'h7FF);
        send_text("\033[1;7;31;42mA\033[0m");
        send_byte(8'hFF);
        send_byte(8'd127);
        send_byte(8'd1);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_text("\033[99999;200H");
        send_text("XY");
        send_read(11'(NCELLS - 1));
        send_text("\033x\033[5!\033[?25l\033[38;5;12;48;2;1;2;3m\033[1;2;3;4;5;6;7;8;9;10m");
        send_text("Z\033[2J\033[?25h");
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_read(pick_index());
        quiet_stretch = 0;

        // Random part: reads, text and well-formed sequences, some controls and noise.
        sent = 0;
        while (sent < 2000) begin
            int r;
            quiet_stretch = (sent >= 800 && sent < 1000);
            r = $urandom_range(99);
            if (r < 30) begin send_read(pick_index()); sent++; end
            else if (r < 55) begin send_byte(8'(32 + $urandom_range(94))); sent++; end
            else if (r < 75) begin send_sequence(); sent += 5; end
            else if (r < 82) begin
                send_byte($urandom_range(3) == 0 ? CH_LF : CH_CR); sent++;
            end
            else if (r < 88) begin
                send_byte($urandom_range(1) ? CH_TAB : CH_BS); sent++;
            end
            else begin send_byte(8'($urandom_range(255))); sent++; end
        end
        send_read(pick_index());
        start <= 1'b0;

        while (grid_sb.pending_reads.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (grid_sb.mismatches == 0 && !timed_out)
            $display("vt100_text_grid_terminal_tb: PASS");
        else
            $display("vt100_text_grid_terminal_tb: FAIL");
        $finish;
    end
endmodule
